// File: hdl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, constants and bit permutations shared by the simplified DES core.
// ----------------------------------------------------------------------------
package sdes_pkg;

    localparam int unsigned KEY_W   = 10;
    localparam int unsigned BLOCK_W = 8;
    localparam int unsigned HALF_W  = 4;
    localparam int unsigned SUBK_W  = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register indexes on the config port
    localparam logic [1:0] REG_KEY    = 2'd0;
    localparam logic [1:0] REG_SBOX_A = 2'd1;
    localparam logic [1:0] REG_SBOX_B = 2'd2;

    localparam logic [DATA_W-1:0] SBOX_A_RESET = 32'd2010651569;
    localparam logic [DATA_W-1:0] SBOX_B_RESET = 32'd3323187941;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [SUBK_W-1:0]  subkey_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [DATA_W-1:0]  table_t;

    // one pipeline slot between stages
    typedef struct packed {
        logic    valid;
        half_t   left;
        half_t   right;
        subkey_t key_now;
        subkey_t key_later;
    } stage_t;

    // permutations, output bit 1 is the msb, tables numbered from the msb
    function automatic key_t p10(input key_t k);
        p10 = {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic subkey_t p8(input key_t k);
        p8 = {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic block_t ip(input block_t b);
        ip = {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic block_t ip_inv(input block_t b);
        ip_inv = {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic subkey_t ep(input half_t h);
        ep = {h[0], h[3], h[2], h[1], h[2], h[1], h[0], h[3]};
    endfunction

    function automatic half_t p4(input half_t s);
        p4 = {s[2], s[0], s[1], s[3]};
    endfunction

    // entry {row, col} of a table holding 16 two-bit entries
    function automatic logic [1:0] sbox_look(input table_t tbl, input logic [3:0] idx);
        sbox_look = tbl[{idx, 1'b0} +: 2];
    endfunction

endpackage

// File: hdl/sdes_keysched.sv
// ----------------------------------------------------------------------------
// sdes_keysched
// Derives round subkeys K1 and K2 from the 10-bit key.
// ----------------------------------------------------------------------------
module sdes_keysched (
    input  sdes_pkg::key_t    cipher_key,
    output sdes_pkg::subkey_t k1,
    output sdes_pkg::subkey_t k2
);
    import sdes_pkg::*;

    key_t         perm;
    logic [4:0]   hi1;
    logic [4:0]   lo1;
    logic [4:0]   hi3;
    logic [4:0]   lo3;

    assign perm = p10(cipher_key);

    // rotate each half left by one, then by two more
    assign hi1 = {perm[8:5], perm[9]};
    assign lo1 = {perm[3:0], perm[4]};
    assign hi3 = {perm[6:5], perm[9:7]};
    assign lo3 = {perm[1:0], perm[4:2]};

    assign k1 = p8({hi1, lo1});
    assign k2 = p8({hi3, lo3});

endmodule

// File: hdl/sdes_round.sv
// ----------------------------------------------------------------------------
// sdes_round
// One registered Feistel round: E/P, subkey xor, two S-boxes, P4 and swap.
// ----------------------------------------------------------------------------
module sdes_round (
    input  logic              clk,
    input  logic              rst_n,
    input  sdes_pkg::table_t  sbox_a,
    input  sdes_pkg::table_t  sbox_b,
    input  sdes_pkg::stage_t  stage_in,
    output sdes_pkg::stage_t  stage_out
);
    import sdes_pkg::*;

    subkey_t mixed;
    half_t   sbox_out;
    half_t   f_out;
    logic    valid_reg;
    half_t   left_reg;
    half_t   right_reg;
    subkey_t key_now_reg;
    subkey_t key_later_reg;

    assign mixed    = ep(stage_in.right) ^ stage_in.key_now;
    // row from the outer bits, column from the inner bits of each nibble
    assign sbox_out = {sbox_look(sbox_a, {mixed[7], mixed[4], mixed[6:5]}),
                       sbox_look(sbox_b, {mixed[3], mixed[0], mixed[2:1]})};
    assign f_out    = p4(sbox_out) ^ stage_in.left;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // halves swap on the way out, next round's key moves up
    always_ff @(posedge clk)
    begin
        left_reg      <= stage_in.right;
        right_reg     <= f_out;
        key_now_reg   <= stage_in.key_later;
        key_later_reg <= stage_in.key_now;
    end

    assign stage_out.valid     = valid_reg;
    assign stage_out.left      = left_reg;
    assign stage_out.right     = right_reg;
    assign stage_out.key_now   = key_now_reg;
    assign stage_out.key_later = key_later_reg;

endmodule

// File: hdl/s_des_block_cipher_core.sv
// ----------------------------------------------------------------------------
// s_des_block_cipher_core
// Simplified DES encrypt / decrypt of one 8-bit block per item.
// ----------------------------------------------------------------------------
// An item is taken whenever start is high; busy stays low, so a new block may
// enter every clock cycle. An item passes the input permutation stage, two
// round stages and the output permutation stage, leaving with done high for
// one cycle; results leave in order and cannot be held off. Subkeys are
// derived directly from the key register. The key and both S-box tables must
// be written over the APB port only while no item is in flight (unenforced).
module s_des_block_cipher_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  sdes_pkg::block_t           block_in,
    output logic                       done,
    output sdes_pkg::block_t           block_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sdes_pkg::ADDR_W-1:0] paddr,
    input  logic [sdes_pkg::DATA_W-1:0] pwdata,
    output logic [sdes_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import sdes_pkg::*;

    key_t     key_reg;
    table_t   sbox_a_reg;
    table_t   sbox_b_reg;
    logic     cfg_wr;
    logic [1:0] reg_idx;
    subkey_t  k1;
    subkey_t  k2;
    block_t   ip_blk;
    logic     s1_valid_reg;
    half_t    s1_left_reg;
    half_t    s1_right_reg;
    subkey_t  s1_key_now_reg;
    subkey_t  s1_key_later_reg;
    stage_t   s1;
    stage_t   s2;
    stage_t   s3;
    logic     done_reg;
    block_t   block_out_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            sbox_a_reg <= SBOX_A_RESET;
            sbox_b_reg <= SBOX_B_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_KEY:    key_reg    <= pwdata[KEY_W-1:0];
                REG_SBOX_A: sbox_a_reg <= pwdata;
                REG_SBOX_B: sbox_b_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY:    prdata = {{(DATA_W-KEY_W){1'b0}}, key_reg};
            REG_SBOX_A: prdata = sbox_a_reg;
            REG_SBOX_B: prdata = sbox_b_reg;
            default:    prdata = '0;
        endcase
    end

    sdes_keysched u_keysched (
        .cipher_key (key_reg),
        .k1         (k1),
        .k2         (k2)
    );

    // input stage: initial permutation and round key order
    assign busy   = 1'b0;
    assign ip_blk = ip(block_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_left_reg      <= ip_blk[7:4];
        s1_right_reg     <= ip_blk[3:0];
        s1_key_now_reg   <= (op == OP_DECRYPT) ? k2 : k1;
        s1_key_later_reg <= (op == OP_DECRYPT) ? k1 : k2;
    end

    assign s1.valid     = s1_valid_reg;
    assign s1.left      = s1_left_reg;
    assign s1.right     = s1_right_reg;
    assign s1.key_now   = s1_key_now_reg;
    assign s1.key_later = s1_key_later_reg;

    sdes_round u_round1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .sbox_a    (sbox_a_reg),
        .sbox_b    (sbox_b_reg),
        .stage_in  (s1),
        .stage_out (s2)
    );

    sdes_round u_round2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .sbox_a    (sbox_a_reg),
        .sbox_b    (sbox_b_reg),
        .stage_in  (s2),
        .stage_out (s3)
    );

    // output stage: undo the last swap, then inverse permutation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        block_out_reg <= ip_inv({s3.right, s3.left});
    end

    assign done      = done_reg;
    assign block_out = block_out_reg;

endmodule

// File: hdl/sdes_checker.sv
// ----------------------------------------------------------------------------
// sdes_checker
// Port-level checks on the simplified DES core, bound to the top level.
// ----------------------------------------------------------------------------
module sdes_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic psel,
    input logic penable,
    input logic pready
);

    // the core never holds off an item
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every accepted item comes out after a fixed latency
    a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("item did not complete after four cycles");

    // no result without a matching item taken before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching item");

    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("apb access not ready");

endmodule

bind s_des_block_cipher_core sdes_checker u_sdes_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .psel    (psel),
    .penable (penable),
    .pready  (pready)
);

// File: sim/s_des_block_cipher_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_des_block_cipher_core_test
// Self-checking bench for the simplified DES core: known-answer blocks under
// the textbook S-boxes, then random blocks in bursts under several key and
// S-box settings loaded over APB, the rest checked against a cipher model.
// ----------------------------------------------------------------------------
module s_des_block_cipher_core_test;

    import sdes_pkg::*;

    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned FLUSH_CYCLES  = 8;
    localparam int unsigned PHASES        = 10;
    localparam int unsigned PHASE_ITEMS   = 130;
    localparam int unsigned DIRECTED_ROWS = 12;

    // index with no register behind it
    localparam logic [1:0] REG_NONE = 2'd3;

    // textbook S-boxes, packed the same way as the table registers
    localparam table_t SBOX_A_BOOK = 32'hB7D81BB1;
    localparam table_t SBOX_B_BOOK = 32'hC613D2E4;

    // permutation tables, bit positions counted from 1 at the msb
    localparam logic [39:0] P10_TAB   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                         4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
    localparam logic [39:0] P8_TAB    = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4,
                                         4'd8, 4'd5, 4'd10, 4'd9};
    localparam logic [39:0] IP_TAB    = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1,
                                         4'd4, 4'd8, 4'd5, 4'd7};
    localparam logic [39:0] EP_TAB    = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3,
                                         4'd2, 4'd3, 4'd4, 4'd1};
    localparam logic [39:0] P4_TAB    = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};
    localparam logic [39:0] IPINV_TAB = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5,
                                         4'd7, 4'd2, 4'd8, 4'd6};

    typedef struct packed {
        logic   op;
        block_t blk;
        logic   known;
        block_t want;
    } probe_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               op;
    block_t             block_in;
    logic               done;
    block_t             block_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // known answer travelling with the item on the input side
    logic               pinned_valid;
    block_t             pinned_out;

    key_t               key_mirror;
    table_t             sbox_a_mirror;
    table_t             sbox_b_mirror;
    block_t             cipher_due_q[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    s_des_block_cipher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [9:0] permute_bits(input logic [9:0] v, input int unsigned in_w,
                                                 input logic [39:0] tab, input int unsigned n);
        logic [9:0]  r;
        int unsigned pos;
        r = '0;
        for (int j = 0; j < n; j++)
        begin
            pos = tab[4*(n-1-j) +: 4];
            r = {r[8:0], v[in_w - pos]};
        end
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] h, input int unsigned k);
        logic [9:0] d;
        d = {h, h} << k;
        return d[9:5];
    endfunction

    function automatic half_t feistel_mix(input half_t half, input subkey_t sk);
        logic [9:0] t;
        logic [7:0] x;
        logic [3:0] s;
        logic [3:0] ia;
        logic [3:0] ib;
        t  = permute_bits({6'd0, half}, 4, EP_TAB, 8);
        x  = t[7:0] ^ sk;
        // row from the outer bits, column from the inner pair
        ia = {x[7], x[4], x[6:5]};
        ib = {x[3], x[0], x[2:1]};
        s  = {sbox_a_mirror[2*ia +: 2], sbox_b_mirror[2*ib +: 2]};
        t  = permute_bits({6'd0, s}, 4, P4_TAB, 4);
        return t[3:0];
    endfunction

    function automatic block_t sdes_crypt(input logic dir, input block_t b);
        logic [9:0] t;
        logic [4:0] hi;
        logic [4:0] lo;
        subkey_t    k1;
        subkey_t    k2;
        subkey_t    ka;
        subkey_t    kb;
        half_t      a;
        half_t      c;
        t  = permute_bits(key_mirror, 10, P10_TAB, 10);
        hi = rotl5(t[9:5], 1);
        lo = rotl5(t[4:0], 1);
        t  = permute_bits({hi, lo}, 10, P8_TAB, 8);
        k1 = t[7:0];
        hi = rotl5(hi, 2);
        lo = rotl5(lo, 2);
        t  = permute_bits({hi, lo}, 10, P8_TAB, 8);
        k2 = t[7:0];
        ka = (dir == OP_DECRYPT) ? k2 : k1;
        kb = (dir == OP_DECRYPT) ? k1 : k2;
        t  = permute_bits({2'd0, b}, 8, IP_TAB, 8);
        a  = feistel_mix(t[3:0], ka) ^ t[7:4];
        c  = feistel_mix(a, kb) ^ t[3:0];
        t  = permute_bits({2'd0, c, a}, 8, IPINV_TAB, 8);
        return t[7:0];
    endfunction

    // run under key 1010000010 and the textbook S-boxes
    function automatic probe_t directed_row(input int i);
        case (i)
            0:       return '{OP_ENCRYPT, 8'h97, 1'b1, 8'h38};
            1:       return '{OP_DECRYPT, 8'h38, 1'b1, 8'h97};
            2:       return '{OP_ENCRYPT, 8'h00, 1'b0, 8'h00};
            3:       return '{OP_ENCRYPT, 8'hFF, 1'b0, 8'h00};
            4:       return '{OP_DECRYPT, 8'h00, 1'b0, 8'h00};
            5:       return '{OP_DECRYPT, 8'hFF, 1'b0, 8'h00};
            6:       return '{OP_ENCRYPT, 8'h01, 1'b0, 8'h00};
            7:       return '{OP_ENCRYPT, 8'h80, 1'b0, 8'h00};
            8:       return '{OP_DECRYPT, 8'h55, 1'b0, 8'h00};
            9:       return '{OP_DECRYPT, 8'hAA, 1'b0, 8'h00};
            10:      return '{OP_ENCRYPT, 8'h0F, 1'b0, 8'h00};
            default: return '{OP_DECRYPT, 8'hF0, 1'b0, 8'h00};
        endcase
    endfunction

    // predict on accept, check on done
    always @(posedge clk)
    begin : watch_ports
        block_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (cipher_due_q.size() == 0)
                begin
                    $display("%0t: block_out expected none, actual %02h", $time, block_out);
                    mismatches++;
                end
                else
                begin
                    want = cipher_due_q.pop_front();
                    if (block_out !== want)
                    begin
                        $display("%0t: block_out expected %02h, actual %02h",
                                 $time, want, block_out);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                cipher_due_q.push_back(pinned_valid ? pinned_out : sdes_crypt(op, block_in));
            if (done || (start && !busy) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        do @(posedge clk); while (idle_cycles < STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(input logic dir, input block_t b, input logic known,
                             input block_t want);
        start        <= 1'b1;
        op           <= dir;
        block_in     <= b;
        pinned_valid <= known;
        pinned_out   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // start low for the requested gap, with junk on the data inputs
    task automatic idle_gap(input int cycles);
        for (int g = 0; g < cycles; g++)
        begin
            start    <= 1'b0;
            op       <= 1'($urandom);
            block_in <= 8'($urandom);
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (cipher_due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY:    key_mirror    = data[KEY_W-1:0];
            REG_SBOX_A: sbox_a_mirror = data;
            REG_SBOX_B: sbox_b_mirror = data;
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic cfg_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: prdata at %0h expected %08h, actual %08h",
                     $time, {idx, 2'b00}, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_all_regs();
        cfg_check(REG_KEY, DATA_W'(key_mirror));
        cfg_check(REG_SBOX_A, sbox_a_mirror);
        cfg_check(REG_SBOX_B, sbox_b_mirror);
    endtask

    task automatic run_random(input int count, input int hold_at);
        int     burst_left;
        int     pick;
        block_t b;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                wait_drained();
            pick = $urandom_range(0, 7);
            b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_item(1'($urandom), b, 1'b0, 8'h00);
            burst_left--;
            if (burst_left == 0)
            begin
                idle_gap($urandom_range(0, 8));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    initial
    begin
        probe_t row;
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_ENCRYPT;
        block_in      = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pinned_valid  = 1'b0;
        pinned_out    = '0;
        key_mirror    = '0;
        sbox_a_mirror = SBOX_A_RESET;
        sbox_b_mirror = SBOX_B_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:  ;   // reset values
                1:
                begin
                    cfg_write(REG_KEY, 32'h0000_0282);
                    cfg_write(REG_SBOX_A, SBOX_A_BOOK);
                    cfg_write(REG_SBOX_B, SBOX_B_BOOK);
                end
                2:
                begin
                    // upper bits of the key word are dropped
                    cfg_write(REG_KEY, 32'hFFFF_FFFF);
                    cfg_write(REG_SBOX_A, 32'h0000_0000);
                    cfg_write(REG_SBOX_B, 32'hFFFF_FFFF);
                end
                3:
                begin
                    cfg_write(REG_KEY, 32'hFFFF_FC00);
                    cfg_write(REG_SBOX_A, 32'hFFFF_FFFF);
                    cfg_write(REG_SBOX_B, 32'h0000_0000);
                    cfg_write(REG_NONE, $urandom);
                end
                default:
                begin
                    cfg_write(REG_KEY, $urandom);
                    cfg_write(REG_SBOX_A, $urandom);
                    cfg_write(REG_SBOX_B, $urandom);
                    if (phase % 2 == 0)
                        cfg_write(REG_NONE, $urandom);
                end
            endcase
            check_all_regs();

            if (phase == 1)
            begin
                for (int i = 0; i < DIRECTED_ROWS; i++)
                begin
                    row = directed_row(i);
                    send_item(row.op, row.blk, row.known, row.want);
                    if (i % 4 == 3)
                        idle_gap(i % 3);
                end
            end

            run_random(PHASE_ITEMS, (phase == 3) ? PHASE_ITEMS / 2 : -1);
            wait_drained();
        end

        repeat (FLUSH_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/sdes_pkg.sv
hdl/sdes_keysched.sv
hdl/sdes_round.sv
hdl/s_des_block_cipher_core.sv
hdl/sdes_checker.sv
sim/s_des_block_cipher_core_test.sv
